[hdl/vfa_pkg.sv]
// Package for the three-component fixed-point vector unit.
// Holds the request and response types and the command codes.
// No dependencies.
package vfa_pkg;

  localparam logic [3:0] CMD_ADD       = 4'd0;
  localparam logic [3:0] CMD_SUB       = 4'd1;
  localparam logic [3:0] CMD_NEGATE    = 4'd2;
  localparam logic [3:0] CMD_MUL       = 4'd3;
  localparam logic [3:0] CMD_SCALE     = 4'd4;
  localparam logic [3:0] CMD_DIV       = 4'd5;
  localparam logic [3:0] CMD_DIVSCALAR = 4'd6;
  localparam logic [3:0] CMD_DOT       = 4'd7;
  localparam logic [3:0] CMD_CROSS     = 4'd8;
  localparam logic [3:0] CMD_LENGTH    = 4'd9;
  localparam logic [3:0] CMD_NORMALIZE = 4'd10;
  localparam logic [3:0] CMD_EQUAL     = 4'd11;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] scale;
  } req_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_scalar;
    logic               equal;
    logic               status;
    logic               saturated;
  } rsp_t;

endpackage

[hdl/vec3_fixed_alu.sv]
// Three-component vector unit in signed fixed point, fully pipelined.
// Depends on vfa_pkg for the request/response types and command codes.
//
// Usage:
//   Request channel: req_valid / req_stall / req. A request is taken at a
//   rising edge with req_valid high and req_stall low.
//   Response channel: rsp_valid / rsp_stall / rsp, one response per request,
//   in request order.
//   Pipeline: four stages of operand select, multiply, sum and
//   rounding, a 32-stage square-root pipeline, one length stage, a
//   (32 + FRAC_BITS)-stage restoring divider and the output register.
//   Throughput: one request per cycle unless stalled; every command takes the same path.
//   Stall: while rsp_valid is high and rsp_stall is high, the whole pipeline
//   holds and req_stall is raised; nothing is lost or repeated.
//   Reset: rst (synchronous) clears all valid bits; no clearing pass.
module vec3_fixed_alu
  import vfa_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int SQ_STAGES = 32;
  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

  typedef struct packed {
    logic [3:0]             cmd;
    logic [2:0][31:0]       vec;
    logic [31:0]            scalar;
    logic                   eq;
    logic                   dz;
    logic                   sat;
    logic [2:0]             nneg;
    logic [2:0][NW-1:0]     nmag;
    logic [2:0]             dneg;
    logic [2:0][32:0]       dmag;
  } work_t;

  function automatic logic ovf(input logic signed [65:0] v);
    return (v > S32_MAX) || (v < S32_MIN);
  endfunction

  function automatic logic [31:0] clamp(input logic signed [65:0] v);
    if (v > S32_MAX) begin
      return 32'h7fffffff;
    end else if (v < S32_MIN) begin
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [32:0] abs33(input logic signed [31:0] v);
    logic signed [32:0] w;
    w = 33'(v);
    return (w < 0) ? 33'(-w) : 33'(w);
  endfunction

  logic en;
  assign en = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  // stage 1: register request
  logic s1_v;
  req_t s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= req_valid;
    end
    if (en) begin
      s1 <= req;
    end
  end

  // stage 2: operand select, products, add/sub/negate
  logic signed [31:0] a1 [3];
  logic signed [31:0] b1 [3];
  logic signed [31:0] pa [3];
  logic signed [31:0] pb [3];
  logic signed [31:0] qa [3];
  logic signed [31:0] qb [3];
  logic signed [32:0] as_n [3];

  always_comb begin
    a1[0] = s1.ax;
    a1[1] = s1.ay;
    a1[2] = s1.az;
    b1[0] = s1.bx;
    b1[1] = s1.by;
    b1[2] = s1.bz;
    qa[0] = a1[2];
    qb[0] = b1[1];
    qa[1] = a1[0];
    qb[1] = b1[2];
    qa[2] = a1[1];
    qb[2] = b1[0];
    for (int i = 0; i < 3; i++) begin
      pa[i] = a1[i];
      if (s1.command == CMD_SCALE) begin
        pb[i] = s1.scale;
      end else if (s1.command inside {CMD_LENGTH, CMD_NORMALIZE}) begin
        pb[i] = a1[i];
      end else begin
        pb[i] = b1[i];
      end
      case (s1.command)
        CMD_ADD:    as_n[i] = 33'(a1[i]) + 33'(b1[i]);
        CMD_SUB:    as_n[i] = 33'(a1[i]) - 33'(b1[i]);
        CMD_NEGATE: as_n[i] = -33'(a1[i]);
        default:    as_n[i] = '0;
      endcase
    end
    if (s1.command == CMD_CROSS) begin
      pa[0] = a1[1];
      pb[0] = b1[2];
      pa[1] = a1[2];
      pb[1] = b1[0];
      pa[2] = a1[0];
      pb[2] = b1[1];
    end
  end

  logic s2_v;
  req_t s2;
  logic signed [63:0] s2_p [3];
  logic signed [63:0] s2_q [3];
  logic signed [32:0] s2_as [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
    if (en) begin
      s2 <= s1;
      for (int i = 0; i < 3; i++) begin
        s2_p[i]  <= pa[i] * pb[i];
        s2_q[i]  <= qa[i] * qb[i];
        s2_as[i] <= as_n[i];
      end
    end
  end

  // stage 3: lane sums and dot sum
  logic s3_v;
  req_t s3;
  logic signed [65:0] s3_ls [3];
  logic signed [65:0] s3_sum;
  logic signed [32:0] s3_as [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
    if (en) begin
      s3     <= s2;
      s3_sum <= 66'(s2_p[0]) + 66'(s2_p[1]) + 66'(s2_p[2]);
      for (int i = 0; i < 3; i++) begin
        s3_ls[i] <= (s2.command == CMD_CROSS) ? 66'(s2_p[i]) - 66'(s2_q[i]) : 66'(s2_p[i]);
        s3_as[i] <= s2_as[i];
      end
    end
  end

  // stage 4: round, saturate, set up square root and divider operands
  work_t s4_n;
  logic signed [65:0] rl [3];
  logic signed [65:0] rd;
  logic signed [31:0] a3 [3];
  logic signed [31:0] b3 [3];

  always_comb begin
    a3[0] = s3.ax;
    a3[1] = s3.ay;
    a3[2] = s3.az;
    b3[0] = s3.bx;
    b3[1] = s3.by;
    b3[2] = s3.bz;
    rd = (s3_sum + HALF) >>> FRAC_BITS;
    s4_n = '0;
    s4_n.cmd = s3.command;
    for (int i = 0; i < 3; i++) begin
      rl[i] = (s3_ls[i] + HALF) >>> FRAC_BITS;
      s4_n.nneg[i] = a3[i][31];
      s4_n.nmag[i] = NW'(abs33(a3[i])) << FRAC_BITS;
      if (s3.command inside {CMD_ADD, CMD_SUB, CMD_NEGATE}) begin
        s4_n.vec[i] = clamp(66'(s3_as[i]));
        s4_n.sat = s4_n.sat | ovf(66'(s3_as[i]));
      end else if (s3.command inside {CMD_MUL, CMD_SCALE, CMD_CROSS}) begin
        s4_n.vec[i] = clamp(rl[i]);
        s4_n.sat = s4_n.sat | ovf(rl[i]);
      end
      if (s3.command == CMD_DIV) begin
        s4_n.dneg[i] = b3[i][31];
        s4_n.dmag[i] = abs33(b3[i]);
      end else if (s3.command == CMD_DIVSCALAR) begin
        s4_n.dneg[i] = s3.scale[31];
        s4_n.dmag[i] = abs33(s3.scale);
      end
    end
    case (s3.command)
      CMD_DOT: begin
        s4_n.scalar = clamp(rd);
        s4_n.sat = ovf(rd);
      end
      CMD_DIV: begin
        s4_n.dz = (s3.bx == 0) || (s3.by == 0) || (s3.bz == 0);
      end
      CMD_DIVSCALAR: begin
        s4_n.dz = (s3.scale == 0);
      end
      CMD_EQUAL: begin
        s4_n.eq = (s3.ax == s3.bx) && (s3.ay == s3.by) && (s3.az == s3.bz);
      end
      default: begin
      end
    endcase
  end

  // square root pipeline, one result bit per stage
  logic        sq_v [SQ_STAGES+1];
  work_t       sq_w [SQ_STAGES+1];
  logic [63:0] sq_x [SQ_STAGES+1];
  logic [63:0] sq_r [SQ_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= s3_v;
    end
    if (en) begin
      sq_w[0] <= s4_n;
      sq_x[0] <= s3_sum[63:0];
      sq_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
    localparam logic [64:0] BIT = 65'd1 << (62 - 2 * k);
    logic [64:0] t;
    logic        ge;

    always_comb begin
      t  = {1'b0, sq_r[k]} + BIT;
      ge = {1'b0, sq_x[k]} >= t;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
      if (en) begin
        sq_w[k+1] <= sq_w[k];
        sq_x[k+1] <= ge ? sq_x[k] - t[63:0] : sq_x[k];
        sq_r[k+1] <= ge ? (sq_r[k] >> 1) + BIT[63:0] : sq_r[k] >> 1;
      end
    end
  end

  // length stage: round root, feed normalize divisor
  work_t       e_n;
  logic [32:0] len;

  always_comb begin
    e_n = sq_w[SQ_STAGES];
    len = 33'(sq_r[SQ_STAGES][31:0]) + 33'(sq_x[SQ_STAGES] > sq_r[SQ_STAGES]);
    if (e_n.cmd == CMD_LENGTH) begin
      if (len > 33'd2147483647) begin
        e_n.scalar = 32'h7fffffff;
        e_n.sat = 1'b1;
      end else begin
        e_n.scalar = len[31:0];
      end
    end
    if (e_n.cmd == CMD_NORMALIZE) begin
      e_n.dz = (len == '0);
      for (int i = 0; i < 3; i++) begin
        e_n.dmag[i] = len;
      end
    end
  end

  // restoring divider, one quotient bit per stage
  logic          dv_v   [NW+1];
  work_t         dv_w   [NW+1];
  logic [32:0]   dv_rem [NW+1][3];
  logic [NW-1:0] dv_q   [NW+1][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[SQ_STAGES];
    end
    if (en) begin
      dv_w[0] <= e_n;
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= '0;
        dv_q[0][i]   <= '0;
      end
    end
  end

  for (genvar j = 0; j < NW; j++) begin : g_div
    logic [33:0] sh [3];
    logic        ge [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        sh[i] = {dv_rem[j][i], dv_w[j].nmag[i][NW-1-j]};
        ge[i] = sh[i] >= {1'b0, dv_w[j].dmag[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
      if (en) begin
        dv_w[j+1] <= dv_w[j];
        for (int i = 0; i < 3; i++) begin
          dv_rem[j+1][i] <= ge[i] ? 33'(sh[i] - {1'b0, dv_w[j].dmag[i]}) : sh[i][32:0];
          dv_q[j+1][i]   <= {dv_q[j][i][NW-2:0], ge[i]};
        end
      end
    end
  end

  // output assembly and register
  rsp_t             rsp_n;
  work_t            fw;
  logic [2:0][31:0] vec;
  logic             sat;
  logic             neg;
  logic [NW-1:0]    qm;

  always_comb begin
    fw  = dv_w[NW];
    vec = fw.vec;
    sat = fw.sat;
    neg = 1'b0;
    qm  = '0;
    if ((fw.cmd inside {CMD_DIV, CMD_DIVSCALAR, CMD_NORMALIZE}) && !fw.dz) begin
      for (int i = 0; i < 3; i++) begin
        neg = fw.nneg[i] ^ fw.dneg[i];
        qm  = dv_q[NW][i];
        if (!neg && (qm > NW'(32'h7fffffff))) begin
          vec[i] = 32'h7fffffff;
          sat = 1'b1;
        end else if (neg && (qm > NW'(33'h080000000))) begin
          vec[i] = 32'h80000000;
          sat = 1'b1;
        end else begin
          vec[i] = neg ? (~qm[31:0] + 32'd1) : qm[31:0];
        end
      end
    end
    rsp_n.res_x      = vec[0];
    rsp_n.res_y      = vec[1];
    rsp_n.res_z      = vec[2];
    rsp_n.res_scalar = fw.scalar;
    rsp_n.equal      = fw.eq;
    rsp_n.status     = fw.dz;
    rsp_n.saturated  = sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= dv_v[NW];
    end
    if (en) begin
      rsp <= rsp_n;
    end
  end

endmodule

[hdl/vfa_checker.sv]
// Port-level checks for the fixed-point vector unit, bound to its top level.
// Depends on vfa_pkg for the response type.
module vfa_checker
  import vfa_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    !rsp_stall |-> !req_stall)
    else $error("request stalled while response side is free");

  a_dz: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> rsp.res_x == 0 && rsp.res_y == 0 && rsp.res_z == 0
      && !rsp.saturated && !rsp.equal)
    else $error("divide-by-zero response not cleared");

  a_eq: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.equal |-> rsp.res_x == 0 && rsp.res_y == 0 && rsp.res_z == 0
      && rsp.res_scalar == 0 && !rsp.saturated)
    else $error("equal response carries data");

endmodule

bind vec3_fixed_alu vfa_checker u_vfa_checker (.*);
